// ===== rtl/core/gsa_pkg.sv =====
package gsa_pkg;

  localparam int SLOTS        = 64;
  localparam int GEN_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);

  typedef logic [1:0] action_t;
  localparam action_t ACT_ALLOC = 2'd0;
  localparam action_t ACT_FREE  = 2'd1;
  localparam action_t ACT_CHECK = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_STALE = 2'd2
  } status_t;

  typedef struct packed {
    logic                active;
    logic [GEN_BITS-1:0] gen;
  } meta_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } gsa_cmd_t;

endpackage

// ===== rtl/core/generational_slot_allocator.sv =====
// Channel   Handshake             Fields
// request   in_valid / in_stall   action, handle_index, handle_generation, payload
// result    out_valid / out_stall ok, status, slot_index, slot_generation, payload_out
//
// Slot table memories are read when a request is accepted (S_IDLE), then written
// back with the free-head and used-count update in S_EXEC once the result can go.
// Synchronous reset empties the free list and zeroes the used count.
// A waiting result does not block the next request; a stalled result only
// holds the S_EXEC write-back of the request behind it.
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic [IDX_W-1:0]        handle_index,
  input  logic [GEN_BITS-1:0]     handle_generation,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    ok,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        slot_index,
  output logic [GEN_BITS-1:0]     slot_generation,
  output logic [PAYLOAD_BITS-1:0] payload_out
);

  gsa_cmd_t cmd;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gsa_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .action            (action),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .payload           (payload),
    .ok                (ok),
    .status            (status),
    .slot_index        (slot_index),
    .slot_generation   (slot_generation),
    .payload_out       (payload_out)
  );

endmodule

// ===== rtl/core/gsa_ram.sv =====
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gsa_ctrl.sv =====
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output gsa_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.commit  = (state == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/gsa_dp.sv =====
module gsa_dp
  import gsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  gsa_cmd_t                cmd,
  input  logic [1:0]              action,
  input  logic [IDX_W-1:0]        handle_index,
  input  logic [GEN_BITS-1:0]     handle_generation,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    ok,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        slot_index,
  output logic [GEN_BITS-1:0]     slot_generation,
  output logic [PAYLOAD_BITS-1:0] payload_out
);

  action_t                 req_action;
  logic [IDX_W-1:0]        req_index;
  logic [GEN_BITS-1:0]     req_gen;
  logic [PAYLOAD_BITS-1:0] req_payload;
  logic [IDX_W-1:0]        sel_slot;
  logic                    sel_fresh;
  logic                    sel_full;

  link_t                   head;
  link_t                   head_next;
  logic [CNT_W-1:0]        used_count;
  logic [CNT_W-1:0]        used_count_next;

  logic                    cap_fresh;
  logic                    cap_full;
  logic [IDX_W-1:0]        cap_slot;
  logic [IDX_W-1:0]        meta_raddr;

  meta_t                   meta_rd;
  meta_t                   meta_wd;
  logic [IDX_W-1:0]        meta_waddr;
  logic                    meta_we;
  link_t                   link_rd;
  link_t                   link_wd;
  logic                    link_we;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic                    pay_we;

  logic                    handle_ok;
  logic                    ok_next;
  status_t                 status_next;
  logic [IDX_W-1:0]        slot_index_next;
  logic [GEN_BITS-1:0]     slot_generation_next;
  logic [PAYLOAD_BITS-1:0] payload_out_next;

  assign cap_fresh  = !head.valid;
  assign cap_full   = !head.valid && (used_count == CNT_W'(SLOTS));
  assign cap_slot   = head.valid ? head.idx : used_count[IDX_W-1:0];
  assign meta_raddr = (action == ACT_ALLOC) ? cap_slot : handle_index;

  gsa_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wd),
    .re    (cmd.capture),
    .raddr (meta_raddr),
    .rdata (meta_rd)
  );

  gsa_ram #(.WIDTH($bits(link_t)), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (req_index),
    .wdata (link_wd),
    .re    (cmd.capture),
    .raddr (head.idx),
    .rdata (link_rd)
  );

  gsa_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (sel_slot),
    .wdata (req_payload),
    .re    (cmd.capture),
    .raddr (handle_index),
    .rdata (pay_rd)
  );

  assign handle_ok = (CNT_W'(req_index) < used_count) && meta_rd.active
                     && (meta_rd.gen == req_gen);

  always_comb begin
    ok_next              = 1'b0;
    status_next          = STAT_STALE;
    slot_index_next      = req_index;
    slot_generation_next = '0;
    payload_out_next     = '0;
    head_next            = head;
    used_count_next      = used_count;
    meta_we              = 1'b0;
    meta_waddr           = req_index;
    meta_wd              = meta_rd;
    link_we              = 1'b0;
    link_wd              = head;
    pay_we               = 1'b0;
    unique case (req_action)
      ACT_ALLOC: begin
        if (sel_full) begin
          status_next     = STAT_FULL;
          slot_index_next = '0;
        end else begin
          ok_next         = 1'b1;
          status_next     = STAT_DONE;
          slot_index_next = sel_slot;
          meta_we         = cmd.commit;
          meta_waddr      = sel_slot;
          meta_wd.active  = 1'b1;
          pay_we          = cmd.commit;
          if (sel_fresh) begin
            meta_wd.gen     = '0;
            used_count_next = used_count + CNT_W'(1);
          end else begin
            slot_generation_next = meta_rd.gen;
            head_next            = link_rd;
          end
        end
      end
      ACT_FREE: begin
        if (handle_ok) begin
          ok_next        = 1'b1;
          status_next    = STAT_DONE;
          meta_we        = cmd.commit;
          meta_wd.active = 1'b0;
          meta_wd.gen    = meta_rd.gen + GEN_BITS'(1);
          link_we        = cmd.commit;
          head_next      = '{valid: 1'b1, idx: req_index};
        end
      end
      ACT_CHECK: begin
        if (handle_ok) begin
          ok_next          = 1'b1;
          status_next      = STAT_DONE;
          payload_out_next = pay_rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action  <= action;
      req_index   <= handle_index;
      req_gen     <= handle_generation;
      req_payload <= payload;
      sel_slot    <= cap_slot;
      sel_fresh   <= cap_fresh;
      sel_full    <= cap_full;
    end
    if (cmd.commit) begin
      ok              <= ok_next;
      status          <= status_next;
      slot_index      <= slot_index_next;
      slot_generation <= slot_generation_next;
      payload_out     <= payload_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      used_count <= '0;
    end else if (cmd.commit) begin
      head       <= head_next;
      used_count <= used_count_next;
    end
  end

endmodule

// ===== bench/generational_slot_allocator_test.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_test;
  import gsa_pkg::*;

  localparam action_t ACT_UNUSED  = 2'd3;
  localparam int      QUIET_LIMIT = 1000;
  localparam int      DRAIN_WAIT  = 20;
  localparam int      QUEUE_DEPTH = 64;

  typedef struct {
    logic                    ok;
    status_t                 status;
    logic [IDX_W-1:0]        index;
    logic [GEN_BITS-1:0]     gen;
    logic [PAYLOAD_BITS-1:0] word;
  } outcome_t;

  typedef struct {
    action_t                 action;
    logic [IDX_W-1:0]        index;
    logic [GEN_BITS-1:0]     gen;
    logic [PAYLOAD_BITS-1:0] word;
    outcome_t                want;
  } request_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              action = '0;
  logic [IDX_W-1:0]        handle_index = '0;
  logic [GEN_BITS-1:0]     handle_generation = '0;
  logic [PAYLOAD_BITS-1:0] payload = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    ok;
  logic [1:0]              status;
  logic [IDX_W-1:0]        slot_index;
  logic [GEN_BITS-1:0]     slot_generation;
  logic [PAYLOAD_BITS-1:0] payload_out;

  // slot table as the allocator should see it, in request order
  logic                    live [SLOTS];
  logic [GEN_BITS-1:0]     slot_gen_now [SLOTS];
  link_t                   next_free [SLOTS];
  logic [PAYLOAD_BITS-1:0] stored_word [SLOTS];
  link_t                   free_top;
  int                      slots_used;

  request_t requests_waiting [$];
  outcome_t outcomes_due [$];

  int failures = 0;
  int quiet_cycles = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_run = 0;

  generational_slot_allocator i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .payload           (payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .ok                (ok),
    .status            (status),
    .slot_index        (slot_index),
    .slot_generation   (slot_generation),
    .payload_out       (payload_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic handle_live(logic [IDX_W-1:0] hidx, logic [GEN_BITS-1:0] g);
    return int'(hidx) < slots_used && live[hidx] && slot_gen_now[hidx] == g;
  endfunction

  function automatic outcome_t apply_request(action_t act, logic [IDX_W-1:0] hidx,
                                             logic [GEN_BITS-1:0] g,
                                             logic [PAYLOAD_BITS-1:0] word);
    outcome_t o;
    int       s;
    o.ok     = 1'b0;
    o.status = STAT_STALE;
    o.index  = hidx;
    o.gen    = '0;
    o.word   = '0;
    case (act)
      ACT_ALLOC: begin
        s = -1;
        if (free_top.valid) begin
          s = free_top.idx;
          free_top = next_free[s];
        end else if (slots_used < SLOTS) begin
          s = slots_used;
          slots_used++;
        end
        if (s < 0) begin
          o.status = STAT_FULL;
          o.index  = '0;
        end else begin
          stored_word[s] = word;
          live[s]        = 1'b1;
          o.ok           = 1'b1;
          o.status       = STAT_DONE;
          o.index        = IDX_W'(s);
          o.gen          = slot_gen_now[s];
        end
      end
      ACT_FREE: begin
        if (handle_live(hidx, g)) begin
          live[hidx]         = 1'b0;
          slot_gen_now[hidx] = slot_gen_now[hidx] + 1'b1;
          next_free[hidx]    = free_top;
          free_top.valid     = 1'b1;
          free_top.idx       = hidx;
          o.ok               = 1'b1;
          o.status           = STAT_DONE;
        end
      end
      ACT_CHECK: begin
        if (handle_live(hidx, g)) begin
          o.ok     = 1'b1;
          o.status = STAT_DONE;
          o.word   = stored_word[hidx];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic queue_request(input action_t act, input logic [IDX_W-1:0] hidx,
                               input logic [GEN_BITS-1:0] g,
                               input logic [PAYLOAD_BITS-1:0] word, output outcome_t o);
    request_t r;
    while (requests_waiting.size() >= QUEUE_DEPTH) @(negedge clk);
    r.action = act;
    r.index  = hidx;
    r.gen    = g;
    r.word   = word;
    r.want   = apply_request(act, hidx, g, word);
    o        = r.want;
    requests_waiting.insert(requests_waiting.size(), r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    failures++;
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcomes_due.insert(outcomes_due.size(), requests_waiting[0].want);
        void'(requests_waiting.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || requests_waiting.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          in_valid          <= 1'b1;
          action            <= requests_waiting[0].action;
          handle_index      <= requests_waiting[0].index;
          handle_generation <= requests_waiting[0].gen;
          payload           <= requests_waiting[0].word;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = gap_max == 0 ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: alternate stall and go runs of random length
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run != 0) begin
      stall_run--;
    end else begin
      out_stall <= !out_stall && $urandom_range(1, 100) <= stall_pct;
      stall_run = $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        w = outcomes_due.pop_front();
        if (ok !== w.ok)
          report_mismatch($sformatf("ok %b, want %b", ok, w.ok));
        if (status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", status, w.status));
        if (slot_index !== w.index)
          report_mismatch($sformatf("slot_index %0d, want %0d", slot_index, w.index));
        if (slot_generation !== w.gen)
          report_mismatch($sformatf("slot_generation %h, want %h", slot_generation, w.gen));
        if (payload_out !== w.word)
          report_mismatch($sformatf("payload_out %h, want %h", payload_out, w.word));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("generational_slot_allocator_test NOT OK");
      $finish;
    end
  end

  initial begin
    outcome_t                o;
    int                      seg, pick, start, k, alloc_pct;
    logic [IDX_W-1:0]        keep_idx, hidx;
    logic [GEN_BITS-1:0]     keep_gen, g;
    logic [PAYLOAD_BITS-1:0] word;
    logic                    found;
    int                      alloc_mix [4];

    alloc_mix = '{95, 80, 10, 50};
    for (k = 0; k < SLOTS; k++) begin
      live[k]         = 1'b0;
      slot_gen_now[k] = '0;
      next_free[k]    = '0;
      stored_word[k]  = '0;
    end
    free_top   = '0;
    slots_used = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    queue_request(ACT_CHECK, 0, 0, 0, o);
    queue_request(ACT_FREE, '1, '1, '1, o);
    queue_request(ACT_ALLOC, '1, '1, '0, o);
    queue_request(ACT_ALLOC, 0, 0, '1, o);
    queue_request(ACT_ALLOC, 2, 16'h1234, 32'ha5a5_5a5a, o);
    queue_request(ACT_CHECK, 0, 0, '1, o);
    queue_request(ACT_CHECK, 1, 0, 0, o);
    queue_request(ACT_CHECK, 1, '1, 0, o);
    queue_request(ACT_FREE, 1, 0, 0, o);
    queue_request(ACT_FREE, 1, 0, 0, o);
    queue_request(ACT_CHECK, 1, 0, 0, o);
    queue_request(ACT_CHECK, 1, 1, 0, o);
    queue_request(ACT_FREE, 0, 0, 0, o);
    queue_request(ACT_ALLOC, 0, 0, 32'h0000_ffff, o);
    queue_request(ACT_ALLOC, 0, 0, 32'hffff_0000, o);
    queue_request(ACT_ALLOC, 0, 0, 32'h5a5a_a5a5, o);
    queue_request(ACT_UNUSED, 2, 0, '1, o);
    queue_request(ACT_CHECK, 2, 0, 0, o);
    queue_request(ACT_CHECK, 0, 1, 0, o);
    queue_request(ACT_CHECK, 3, 0, 0, o);
    queue_request(ACT_CHECK, 63, '1, 0, o);

    // free and reallocate one slot back to back
    gap_max   = 0;
    stall_pct = 0;
    queue_request(ACT_ALLOC, 0, 0, $urandom, o);
    keep_idx = o.index;
    keep_gen = o.gen;
    g        = o.gen;
    repeat (32) begin
      queue_request(ACT_FREE, keep_idx, g, 0, o);
      queue_request(ACT_ALLOC, 0, 0, $urandom, o);
      g = o.gen;
    end
    queue_request(ACT_CHECK, keep_idx, keep_gen, 0, o);

    // random
    for (seg = 0; seg < 19; seg++) begin
      alloc_pct = alloc_mix[seg % 4];
      gap_max   = seg % 3 == 0 ? 0 : $urandom_range(1, 8);
      stall_pct = seg % 3 == 1 ? 0 : $urandom_range(20, 80);
      repeat (45) begin
        pick = $urandom_range(0, 99);
        hidx = IDX_W'($urandom);
        g    = GEN_BITS'($urandom);
        word = $urandom;
        if (pick < 3) begin
          queue_request(ACT_UNUSED, hidx, g, word, o);
        end else if (pick < 3 + alloc_pct) begin
          if ($urandom_range(0, 19) == 0) word = $urandom_range(0, 1) ? '1 : '0;
          queue_request(ACT_ALLOC, hidx, g, word, o);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            start = $urandom_range(0, SLOTS - 1);
            found = 1'b0;
            for (k = 0; k < SLOTS && !found; k++) begin
              if (live[(start + k) % SLOTS]) begin
                hidx  = IDX_W'((start + k) % SLOTS);
                g     = slot_gen_now[hidx];
                found = 1'b1;
              end
            end
          end else if (pick < 85 && slots_used != 0) begin
            hidx = IDX_W'($urandom_range(0, slots_used - 1));
            g    = slot_gen_now[hidx] - 1'b1;
          end
          queue_request($urandom_range(0, 1) ? ACT_FREE : ACT_CHECK, hidx, g, word, o);
        end
      end
    end

    while (requests_waiting.size() != 0 || outcomes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (failures == 0) $display("generational_slot_allocator_test OK");
    else $display("generational_slot_allocator_test NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gsa_pkg.sv
rtl/core/gsa_ram.sv
rtl/core/gsa_ctrl.sv
rtl/core/gsa_dp.sv
rtl/core/generational_slot_allocator.sv
bench/generational_slot_allocator_test.sv
